FILE: rtl/owbm_pkg.sv
`timescale 1ns / 1ps
// owbm_pkg: types and constants for the single-wire byte master.
// No dependencies; imported by onewire_byte_master_unit.

package owbm_pkg;

  localparam int unsigned DurW     = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitsW    = 4;
  localparam int unsigned NumRegs  = 7;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [BitsW-1:0] BitsPerByte = BitsW'(8);

  typedef logic [DurW-1:0] dur_t;

  // Configuration register indices
  localparam logic [RegIdxW-1:0] RegResetLow     = 3'd0;
  localparam logic [RegIdxW-1:0] RegPresenceWait = 3'd1;
  localparam logic [RegIdxW-1:0] RegResetTail    = 3'd2;
  localparam logic [RegIdxW-1:0] RegSlotStart    = 3'd3;
  localparam logic [RegIdxW-1:0] RegWriteHold    = 3'd4;
  localparam logic [RegIdxW-1:0] RegReadSample   = 3'd5;
  localparam logic [RegIdxW-1:0] RegReadTail     = 3'd6;

  localparam dur_t RegResetVals [NumRegs] = '{
    10'd600, 10'd30, 10'd500, 10'd2, 10'd70, 10'd15, 10'd50
  };

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_TAIL  = 4'd3,
    PH_WR_START  = 4'd4,
    PH_WR_HOLD   = 4'd5,
    PH_RD_START  = 4'd6,
    PH_RD_SAMPLE = 4'd7,
    PH_RD_TAIL   = 4'd8
  } phase_e;

endpackage

FILE: rtl/onewire_byte_master_unit.sv
`timescale 1ns / 1ps
// onewire_byte_master_unit: open-drain single-wire master, one word per clock unless stalled.
// Depends on owbm_pkg for phase and command codes and register defaults.
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+-------------------------------------------
// in      | to block  | in_valid_i / in_stall_o | command_i, write_data_i, tick_i, bus_level_i
// out     | from block| out_valid_o / out_stall_i | bus_release_o, busy_res_o, done_res_o,
//         |           |                        | device_missing_o, read_data_o
// cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A word accepted into the input register passes through the phase/counter update into
// the result register. One word per cycle while the result is not stalled.
// Reset sets released_q, phase idle and registers to defaults, not the bus_release_o flop.
// A stalled result holds the update stage; the input register then stalls the source.

module onewire_byte_master_unit
  import owbm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [ByteW-1:0]   write_data_i,
  input  logic               tick_i,
  input  logic               bus_level_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               bus_release_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               device_missing_o,
  output logic [ByteW-1:0]   read_data_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [DurW-1:0]    cfg_data_i
);

  // Configuration registers
  dur_t cfg_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= RegResetVals[i];
      end
    end else if (cfg_valid_i && cfg_ready_o && (32'(cfg_index_i) < NumRegs)) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Input register
  logic             in_v_q;
  cmd_e             cmd_q;
  logic [ByteW-1:0] wdata_q;
  logic             tick_q;
  logic             level_q;
  logic             adv;
  logic             in_acc;

  assign adv        = in_v_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_v_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_acc) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_e'(command_i);
      wdata_q <= write_data_i;
      tick_q  <= tick_i;
      level_q <= bus_level_i;
    end
  end

  // Bus state
  phase_e           phase_q, phase_d;
  dur_t             count_q, count_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic             presence_q, presence_d;
  logic             released_q, released_d;
  logic [ByteW-1:0] rdres_q, rdres_d;
  logic             done_d;

  dur_t             count_inc;
  dur_t             dur;
  logic             ivl_end;
  logic [BitsW-1:0] bits_dec;
  logic             last_bit;

  assign count_inc = count_q + dur_t'(1);
  assign bits_dec  = bits_q - BitsW'(1);
  assign last_bit  = (bits_dec == '0);

  always_comb begin
    unique case (phase_q)
      PH_RST_LOW:   dur = cfg_q[RegResetLow];
      PH_RST_WAIT:  dur = cfg_q[RegPresenceWait];
      PH_RST_TAIL:  dur = cfg_q[RegResetTail];
      PH_WR_START:  dur = cfg_q[RegSlotStart];
      PH_WR_HOLD:   dur = cfg_q[RegWriteHold];
      PH_RD_START:  dur = cfg_q[RegSlotStart];
      PH_RD_SAMPLE: dur = cfg_q[RegReadSample];
      PH_RD_TAIL:   dur = cfg_q[RegReadTail];
      default:      dur = dur_t'(1);
    endcase
  end

  // a zero duration still ends after one tick, since count_inc is at least one
  assign ivl_end = (phase_q != PH_IDLE) && tick_q && (count_inc >= dur);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (phase_q == PH_IDLE) begin
      unique case (cmd_q)
        CMD_RESET: phase_d = PH_RST_LOW;
        CMD_WRITE: phase_d = PH_WR_START;
        CMD_READ:  phase_d = PH_RD_START;
        default:   phase_d = PH_IDLE;
      endcase
    end else if (ivl_end) begin
      unique case (phase_q)
        PH_RST_LOW:   phase_d = PH_RST_WAIT;
        PH_RST_WAIT:  phase_d = PH_RST_TAIL;
        PH_RST_TAIL:  phase_d = PH_IDLE;
        PH_WR_START:  phase_d = PH_WR_HOLD;
        PH_WR_HOLD:   phase_d = last_bit ? PH_IDLE : PH_WR_START;
        PH_RD_START:  phase_d = PH_RD_SAMPLE;
        PH_RD_SAMPLE: phase_d = PH_RD_TAIL;
        PH_RD_TAIL:   phase_d = last_bit ? PH_IDLE : PH_RD_START;
        default:      phase_d = PH_IDLE;
      endcase
    end
  end

  // Datapath and outputs
  always_comb begin
    count_d    = count_q;
    bits_d     = bits_q;
    shift_d    = shift_q;
    presence_d = presence_q;
    released_d = released_q;
    rdres_d    = rdres_q;
    done_d     = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (cmd_q != CMD_NONE) begin
        count_d    = '0;
        released_d = 1'b0;
        if (cmd_q == CMD_WRITE) begin
          shift_d = wdata_q;
          bits_d  = BitsPerByte;
        end else if (cmd_q == CMD_READ) begin
          shift_d = '0;
          bits_d  = BitsPerByte;
        end
      end
    end else if (tick_q) begin
      count_d = ivl_end ? '0 : count_inc;
      if (ivl_end) begin
        unique case (phase_q)
          PH_RST_LOW: begin
            released_d = 1'b1;
          end
          PH_RST_WAIT: begin
            presence_d = level_q;
          end
          PH_RST_TAIL: begin
            done_d = 1'b1;
          end
          PH_WR_START: begin
            released_d = shift_q[0];
          end
          PH_WR_HOLD: begin
            shift_d    = shift_q >> 1;
            bits_d     = bits_dec;
            released_d = last_bit;
            done_d     = last_bit;
          end
          PH_RD_START: begin
            released_d = 1'b1;
          end
          PH_RD_SAMPLE: begin
            shift_d = {level_q, shift_q[ByteW-1:1]};
          end
          PH_RD_TAIL: begin
            bits_d = bits_dec;
            done_d = last_bit;
            if (last_bit) begin
              rdres_d = shift_q;
            end else begin
              released_d = 1'b0;
            end
          end
          default: begin
            released_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      count_q    <= '0;
      bits_q     <= '0;
      shift_q    <= '0;
      presence_q <= 1'b1;
      released_q <= 1'b1;
      rdres_q    <= '0;
    end else if (adv) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      bits_q     <= bits_d;
      shift_q    <= shift_d;
      presence_q <= presence_d;
      released_q <= released_d;
      rdres_q    <= rdres_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bus_release_o    <= released_d;
      busy_res_o       <= (phase_d != PH_IDLE);
      done_res_o       <= done_d;
      device_missing_o <= presence_d;
      read_data_o      <= rdres_d;
    end
  end

  // Checks
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  a_idle_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> released_q)
    else $error("line driven low while idle");

  a_bits_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BitsPerByte)
    else $error("bit count out of range");

  a_adv_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("update stage advanced without a result");

  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_v_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule
